// File: hdl/der_pkg.sv
// Package for the dispatch entry ranker: payload structs, configuration codes,
// strategy codes and scan-state types.
// No dependencies; every RTL file in hdl/ refers to it by scoped names.
package der_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TARGET_VENDOR  = 2'd0,
    CFG_DEVICE_VERSION = 2'd1,
    CFG_STRATEGY       = 2'd2
  } cfg_reg_e;

  // Selection strategies; the fourth code behaves as first compatible
  typedef enum logic [1:0] {
    STRAT_FIRST    = 2'd0,
    STRAT_PRIORITY = 2'd1,
    STRAT_CLOSEST  = 2'd2,
    STRAT_FALLBACK = 2'd3
  } strategy_e;

  localparam int unsigned INDEX_SPACE      = 256;
  localparam logic [1:0]  VERSIONED_VENDOR = 2'd1;
  localparam logic [10:0] DIST_RESET       = 11'h7FF;
  localparam logic signed [8:0] NO_INDEX   = -9'sd1;

  // One table entry
  typedef struct packed {
    logic [3:0]  entry_vendor;
    logic [9:0]  entry_min_version;
    logic [15:0] entry_priority;
    logic        last_entry;
  } der_in_t;

  // One result
  typedef struct packed {
    logic signed [8:0] chosen_index;
    logic              found;
  } der_out_t;

  // Configuration registers
  typedef struct packed {
    logic [1:0] target_vendor;
    logic [9:0] device_version;
    strategy_e  strategy;
  } der_cfg_t;

  // Best entry seen so far in the current table
  typedef struct packed {
    logic        have;
    logic [7:0]  index;
    logic [15:0] priority_val;
    logic [9:0]  min_version;
    logic [10:0] distance;
  } der_best_t;

  // Verdict on one entry
  typedef struct packed {
    logic        take;
    logic [10:0] distance;
  } der_verdict_t;

endpackage

// File: hdl/dispatch_entry_ranker_core.sv
// Top level of the dispatch entry ranker: input register, entry judge,
// best-entry registers and result register. Depends on der_pkg and der_judge.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------
//   in      | in_valid_i / in_stall_o    | in_data_i   (der_pkg::der_in_t)
//   out     | out_valid_o / out_stall_i  | out_data_o  (der_pkg::der_out_t)
//   cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One entry per cycle: an entry is registered, judged and folded into the
// best-entry registers in the next cycle; the last entry of a table also
// loads the result register, which drives out_valid_o. Reset clears the
// scan state (distance to all ones), config and valid flags, not the data
// registers. Only a last entry waiting on a full, stalled result register
// holds the input stage, raising in_stall_o; other entries keep flowing.
module dispatch_entry_ranker_core #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  der_pkg::der_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output der_pkg::der_out_t  out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [9:0]         cfg_data_i
);

  localparam int unsigned LIMIT =
    (MAX_ENTRIES > der_pkg::INDEX_SPACE) ? der_pkg::INDEX_SPACE : MAX_ENTRIES;
  localparam int unsigned CNT_W = $clog2(LIMIT + 1);

  der_pkg::der_cfg_t     cfg_q;
  der_pkg::der_in_t      s1_q;
  logic                  s1_valid_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  der_pkg::der_best_t    best_q, best_d, best_upd;
  der_pkg::der_verdict_t verdict;
  der_pkg::der_out_t     out_q, out_d;
  logic                  out_valid_q;
  logic                  in_range;
  logic                  out_free;
  logic                  s1_adv;
  logic                  s1_load;

  // Configuration writes are always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_vendor  <= '0;
      cfg_q.device_version <= '0;
      cfg_q.strategy       <= der_pkg::STRAT_FIRST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        der_pkg::CFG_TARGET_VENDOR:  cfg_q.target_vendor  <= cfg_data_i[1:0];
        der_pkg::CFG_DEVICE_VERSION: cfg_q.device_version <= cfg_data_i;
        der_pkg::CFG_STRATEGY:       cfg_q.strategy <= der_pkg::strategy_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // Handshake: the input stage advances unless a last entry meets a full result
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_q.last_entry || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign s1_load    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_load || (s1_valid_q && !s1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= in_data_i;
    end
  end

  // Judge the registered entry
  assign in_range = (cnt_q < CNT_W'(LIMIT));

  der_judge u_judge (
    .entry_i    (s1_q),
    .cfg_i      (cfg_q),
    .best_i     (best_q),
    .in_range_i (in_range),
    .verdict_o  (verdict)
  );

  // Fold the entry into the best registers; clear after the last entry
  always_comb begin
    best_upd = best_q;
    if (verdict.take) begin
      best_upd.have         = 1'b1;
      best_upd.index        = 8'(cnt_q);
      best_upd.priority_val = s1_q.entry_priority;
      best_upd.min_version  = s1_q.entry_min_version;
      best_upd.distance     = verdict.distance;
    end

    best_d = best_q;
    cnt_d  = cnt_q;
    if (s1_adv) begin
      if (s1_q.last_entry) begin
        best_d.have         = 1'b0;
        best_d.index        = '0;
        best_d.priority_val = '0;
        best_d.min_version  = '0;
        best_d.distance     = der_pkg::DIST_RESET;
        cnt_d               = '0;
      end else begin
        best_d = best_upd;
        if (in_range) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q               <= '0;
      best_q.have         <= 1'b0;
      best_q.index        <= '0;
      best_q.priority_val <= '0;
      best_q.min_version  <= '0;
      best_q.distance     <= der_pkg::DIST_RESET;
    end else begin
      cnt_q  <= cnt_d;
      best_q <= best_d;
    end
  end

  // Result register
  always_comb begin
    if (best_upd.have) begin
      out_d.chosen_index = {1'b0, best_upd.index};
      out_d.found        = 1'b1;
    end else begin
      out_d.chosen_index = der_pkg::NO_INDEX;
      out_d.found        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_q.last_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_adv && s1_q.last_entry) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_result_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.found ? !out_q.chosen_index[8]
                                 : (out_q.chosen_index == der_pkg::NO_INDEX)))
    else $error("result found flag disagrees with chosen index");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.last_entry) |=> (!best_q.have && cnt_q == '0))
    else $error("scan state not cleared after last entry");

  a_counter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LIMIT))
    else $error("entry counter passed its limit");

  a_best_before_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q.have |-> (best_q.index < cnt_q))
    else $error("best index not below entry counter");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_q.last_entry && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

endmodule

// File: hdl/der_judge.sv
// Compatibility test and compare-against-best for one dispatch table entry.
// Purely combinational; depends on der_pkg.
module der_judge (
  input  der_pkg::der_in_t      entry_i,
  input  der_pkg::der_cfg_t     cfg_i,
  input  der_pkg::der_best_t    best_i,
  input  logic                  in_range_i,
  output der_pkg::der_verdict_t verdict_o
);

  logic        compatible;
  logic        better;
  logic [10:0] ver_gap;

  // Vendor match, plus version floor for the versioned vendor
  always_comb begin
    compatible = (entry_i.entry_vendor == {2'b00, cfg_i.target_vendor});
    if (cfg_i.target_vendor == der_pkg::VERSIONED_VENDOR &&
        entry_i.entry_min_version > cfg_i.device_version) begin
      compatible = 1'b0;
    end
  end

  // Wrapped 11-bit distance between device and required version
  assign ver_gap = {1'b0, cfg_i.device_version} - {1'b0, entry_i.entry_min_version};

  // Compare against the current best under the active strategy
  always_comb begin
    case (cfg_i.strategy)
      der_pkg::STRAT_PRIORITY: begin
        better = (entry_i.entry_priority > best_i.priority_val) ||
                 (entry_i.entry_priority == best_i.priority_val &&
                  entry_i.entry_min_version > best_i.min_version);
      end
      der_pkg::STRAT_CLOSEST: begin
        better = (ver_gap < best_i.distance);
      end
      default: begin
        better = 1'b0;
      end
    endcase
  end

  // First compatible entry within the entry limit is always taken
  assign verdict_o.take     = in_range_i && compatible && (!best_i.have || better);
  assign verdict_o.distance = ver_gap;

endmodule
